// File: rtl/core/lifo_stack_engine_top_assert.svh
// Assertion macros shared by the stack engine RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef LIFO_STACK_ENGINE_TOP_ASSERT_SVH
`define LIFO_STACK_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stack engine assertion failed");

// Next-cycle implication, disabled during reset.
`define LSSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stack engine assertion failed");

`endif

// File: rtl/core/lsse_pkg.sv
// Shared types and constants of the stack engine.
// No dependencies.
`default_nettype none

package lsse_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_DUMP = 2'd2;
	localparam logic [1:0] OP_PEEK = 2'd3;

	localparam word_t EMPTY_MARK = -32'sd1;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic push;    // take the neighbor above, new word enters at the top
		logic pull;    // take the neighbor below
		logic rotate;  // with pull: the last held cell takes the top word
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/lsse_in_if.sv
// Command channel of the stack engine: valid/ready plus opcode and word.
// Depends on lsse_pkg.
`default_nettype none

interface lsse_in_if;
	logic          valid;
	logic          ready;
	logic [1:0]    opcode;
	lsse_pkg::word_t push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lsse_out_if.sv
// Result channel of the stack engine: valid/ready plus status fields.
// Depends on lsse_pkg; CW sizes the entry count.
`default_nettype none

interface lsse_out_if #(parameter int CW = 5);
	logic            valid;
	logic            ready;
	lsse_pkg::word_t item_value;
	logic            item_valid;
	logic [CW-1:0]   entry_count;
	logic            is_empty;
	logic            is_full;
	logic            overflow;
	logic            last;

	modport source (output valid, output item_value, output item_valid,
		output entry_count, output is_empty, output is_full, output overflow,
		output last, input ready);
	modport sink (input valid, input item_value, input item_valid,
		input entry_count, input is_empty, input is_full, input overflow,
		input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lsse_cell.sv
// One storage cell of the stack chain; shifts with its neighbors.
// Depends on lsse_pkg.
`default_nettype none

module lsse_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire                       clk,
	input  wire lsse_pkg::cell_ctrl_t ctrl,
	input  wire [CW-1:0]              count,
	input  wire lsse_pkg::word_t      from_above,
	input  wire lsse_pkg::word_t      from_below,
	input  wire lsse_pkg::word_t      top,
	output lsse_pkg::word_t           data
);

	lsse_pkg::word_t data_q;
	logic            wrap;

	// This cell holds the bottom entry.
	assign wrap = (count == CW'(IDX + 1));
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= from_above;
		end else if (ctrl.pull) begin
			data_q <= (ctrl.rotate && wrap) ? top : from_below;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/lifo_stack_engine_top.sv
// Stack engine of signed 32-bit words: a push/pop chain of cells, a dump
// sequencer and an output register. Depends on lsse_pkg, lsse_in_if,
// lsse_out_if, lsse_cell and lifo_stack_engine_top_assert.svh.
//
// The top of stack sits in cell 0; a push shifts the chain down, a pop
// shifts it up. Push, pop and peek (opcode 3) each give one result. A dump
// gives one result per held entry, top first, one per cycle while the
// output does not stall: the chain rotates by one cell per result over the
// held entries and is back in order after the last one, and the dump holds
// the command channel until its last result is registered. A result sits
// in the output register until it is taken; the next command is accepted
// in the cycle the held result leaves, so a stalled output stalls the
// command channel. After reset the stack is empty; no clearing pass.
`default_nettype none
`include "lifo_stack_engine_top_assert.svh"

module lifo_stack_engine_top #(
	parameter int DEPTH = 16
) (
	input wire           clk,
	input wire           arst_n,
	lsse_in_if.sink      cmd,
	lsse_out_if.source   res
);

	localparam int CW = $clog2(DEPTH + 1);

	lsse_pkg::word_t    cell_d [DEPTH];
	lsse_pkg::cell_ctrl_t ctrl;

	logic [CW-1:0] count_q;
	logic          dump_busy_q;
	logic [CW-1:0] dump_left_q;

	logic            res_valid_q;
	lsse_pkg::word_t item_value_q;
	logic            item_valid_q;
	logic [CW-1:0]   entry_count_q;
	logic            is_empty_q;
	logic            is_full_q;
	logic            overflow_q;
	logic            last_q;

	logic out_free, cmd_fire, full_now, empty_now;
	logic push_ok, pop_mv, dump_go, dump_step;

	logic [CW-1:0]   nx_count;
	lsse_pkg::word_t nx_value;
	logic            nx_valid, nx_ovf, nx_last;

	assign out_free  = !res_valid_q || res.ready;
	assign cmd.ready = !dump_busy_q && out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign dump_step = dump_busy_q && out_free;

	assign full_now  = (count_q == CW'(DEPTH));
	assign empty_now = (count_q == '0);

	assign push_ok = cmd_fire && (cmd.opcode == lsse_pkg::OP_PUSH) && !full_now;
	assign pop_mv  = cmd_fire && (cmd.opcode == lsse_pkg::OP_POP) && !empty_now;
	assign dump_go = cmd_fire && (cmd.opcode == lsse_pkg::OP_DUMP) && !empty_now;

	assign ctrl.push   = push_ok;
	assign ctrl.pull   = pop_mv || dump_go || dump_step;
	assign ctrl.rotate = dump_go || dump_step;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lsse_pkg::word_t above, below;
		if (i == 0) begin : g_first
			assign above = cmd.push_value;
		end else begin : g_mid_a
			assign above = cell_d[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign below = '0;
		end else begin : g_mid_b
			assign below = cell_d[i+1];
		end
		lsse_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.from_above (above),
			.from_below (below),
			.top        (cell_d[0]),
			.data       (cell_d[i])
		);
	end

	// Result of the command being accepted.
	always_comb begin
		nx_count = count_q;
		nx_value = lsse_pkg::EMPTY_MARK;
		nx_valid = 1'b0;
		nx_ovf   = 1'b0;
		nx_last  = 1'b1;
		case (cmd.opcode)
			lsse_pkg::OP_PUSH: begin
				if (full_now) begin
					nx_value = cell_d[0];
					nx_valid = 1'b1;
					nx_ovf   = 1'b1;
				end else begin
					nx_count = count_q + 1'b1;
					nx_value = cmd.push_value;
					nx_valid = 1'b1;
				end
			end
			lsse_pkg::OP_POP: begin
				if (!empty_now) begin
					nx_count = count_q - 1'b1;
				end
				if (count_q > CW'(1)) begin
					nx_value = cell_d[1];
					nx_valid = 1'b1;
				end
			end
			lsse_pkg::OP_DUMP: begin
				if (!empty_now) begin
					nx_value = cell_d[0];
					nx_valid = 1'b1;
					nx_last  = (count_q == CW'(1));
				end
			end
			default: begin
				if (!empty_now) begin
					nx_value = cell_d[0];
					nx_valid = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dump_busy_q <= 1'b0;
			dump_left_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_fire) begin
				count_q     <= nx_count;
				res_valid_q <= 1'b1;
				if (dump_go) begin
					dump_left_q <= count_q - 1'b1;
					dump_busy_q <= (count_q != CW'(1));
				end
			end else if (dump_step) begin
				res_valid_q <= 1'b1;
				dump_left_q <= dump_left_q - 1'b1;
				dump_busy_q <= (dump_left_q != CW'(1));
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload holds while the output stalls.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			item_value_q  <= nx_value;
			item_valid_q  <= nx_valid;
			entry_count_q <= nx_count;
			is_empty_q    <= (nx_count == '0);
			is_full_q     <= (nx_count == CW'(DEPTH));
			overflow_q    <= nx_ovf;
			last_q        <= nx_last;
		end else if (dump_step) begin
			item_value_q  <= cell_d[0];
			item_valid_q  <= 1'b1;
			entry_count_q <= count_q;
			is_empty_q    <= 1'b0;
			is_full_q     <= full_now;
			overflow_q    <= 1'b0;
			last_q        <= (dump_left_q == CW'(1));
		end
	end

	assign res.valid       = res_valid_q;
	assign res.item_value  = item_value_q;
	assign res.item_valid  = item_valid_q;
	assign res.entry_count = entry_count_q;
	assign res.is_empty    = is_empty_q;
	assign res.is_full     = is_full_q;
	assign res.overflow    = overflow_q;
	assign res.last        = last_q;

	`LSSE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`LSSE_ASSERT_NOW(a_dump_left, dump_busy_q, dump_left_q != '0 && dump_left_q < count_q)
	`LSSE_ASSERT_NEXT(a_dump_count_hold, dump_busy_q, count_q == $past(count_q))
	`LSSE_ASSERT_NEXT(a_push_grows, push_ok, count_q == $past(count_q) + 1'b1)
	`LSSE_ASSERT_NEXT(a_dump_emits, dump_step, res.valid && res.item_valid && !res.overflow)

endmodule

`default_nettype wire
